// ===== sv/kftm_pkg.sv =====
// Package for the keyframe time mapper: shared types, register indexes,
// state encodings and fixed constants. No dependencies.
package kftm_pkg;

    localparam logic [31:0] DEFAULT_RATE = 32'h0019_0000;

    localparam logic [2:0] REG_RATE     = 3'd0;
    localparam logic [2:0] REG_SPEED    = 3'd1;
    localparam logic [2:0] REG_TOFF     = 3'd2;
    localparam logic [2:0] REG_TICK_OFF = 3'd3;
    localparam logic [2:0] REG_DUR      = 3'd4;
    localparam logic [2:0] REG_LIMIT    = 3'd5;
    localparam logic [2:0] REG_MODE     = 3'd6;
    localparam logic [2:0] REG_KCOUNT   = 3'd7;

    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_PING   = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;

    typedef struct packed {
        logic [31:0]        rate;
        logic [15:0]        speed;
        logic [31:0]        toff;
        logic signed [15:0] tick_off;
        logic [31:0]        dur;
        logic signed [16:0] limit;
        logic [1:0]         mode;
        logic [8:0]         kcount;
    } t_cfg;

    // one queued item: a key write or a wrapped time ready for lookup
    typedef struct packed {
        logic        func;
        logic [7:0]  slot;
        logic [31:0] value;
        logic [15:0] play_count;
        logic        done;
    } t_job;

    typedef enum logic [2:0] {
        F_IDLE, F_MUL, F_OFFS, F_DIV, F_EMIT
    } t_fst;

    typedef enum logic [2:0] {
        B_IDLE, B_LAST, B_SCAN, B_NEXT, B_WGT, B_DIV, B_OUT
    } t_bst;

endpackage

// ===== sv/keyframe_time_mapper.sv =====
// Keyframe time mapper top level: configuration registers, front, queue, back.
// Depends on kftm_pkg, kftm_front, kftm_queue, kftm_back.
//
// Key writes (func 0) hold the front only to hand the item on and give no
// result. An evaluation holds the front while it forms three 33x16 partial
// products, adds the tick offset, runs a 58-bit restoring division by the
// duration (one bit a cycle) and hands the item on, waiting while the queue
// is full; the front takes no new item until then. The back reads the last key,
// then scans the key-time memory one key at a time (reading one more key when
// the first key already lies past the time), and runs a 48-bit weight division
// when a weight is needed. A two-entry queue lets the front work on the next
// item while the back scans. The key-time memory has no reset; a slot must be
// written before any evaluation reads it.
module keyframe_time_mapper import kftm_pkg::*; #(
    parameter int MAX_KEYS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        i_func,
    input  logic [7:0]  i_key_slot,
    input  logic [31:0] i_key_time,
    input  logic [31:0] i_time_sec,
    input  logic        pop,
    output logic        empty,
    output logic [31:0] o_anim_time,
    output logic [15:0] o_play_count,
    output logic        o_done_res,
    output logic [7:0]  o_frame_index,
    output logic [15:0] o_weight,
    output logic        o_hold_last
);
    t_cfg r_cfg;
    logic q_push, q_full, q_pop, q_empty;
    t_job q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate     <= '0;
            r_cfg.speed    <= 16'd256;
            r_cfg.toff     <= '0;
            r_cfg.tick_off <= '0;
            r_cfg.dur      <= 32'd65536;
            r_cfg.limit    <= '1;
            r_cfg.mode     <= '0;
            r_cfg.kcount   <= 9'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RATE:     r_cfg.rate     <= i_cfg_data;
                REG_SPEED:    r_cfg.speed    <= i_cfg_data[15:0];
                REG_TOFF:     r_cfg.toff     <= i_cfg_data;
                REG_TICK_OFF: r_cfg.tick_off <= i_cfg_data[15:0];
                REG_DUR:      r_cfg.dur      <= i_cfg_data;
                REG_LIMIT:    r_cfg.limit    <= i_cfg_data[16:0];
                REG_MODE:     r_cfg.mode     <= i_cfg_data[1:0];
                REG_KCOUNT:   r_cfg.kcount   <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    kftm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .push       (push),
        .full       (full),
        .i_func     (i_func),
        .i_key_slot (i_key_slot),
        .i_key_time (i_key_time),
        .i_time_sec (i_time_sec),
        .o_q_push   (q_push),
        .o_q_data   (q_in),
        .i_q_full   (q_full)
    );

    kftm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    kftm_back #(.MAX_KEYS(MAX_KEYS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_kcount      (r_cfg.kcount),
        .i_q_data      (q_out),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .pop           (pop),
        .empty         (empty),
        .o_anim_time   (o_anim_time),
        .o_play_count  (o_play_count),
        .o_done_res    (o_done_res),
        .o_frame_index (o_frame_index),
        .o_weight      (o_weight),
        .o_hold_last   (o_hold_last)
    );
endmodule

// ===== sv/kftm_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Standalone; used by the front and back parts of the time mapper.
module kftm_div #(
    parameter int N_W = 58,
    parameter int D_W = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_busy,
    output logic [N_W-1:0] o_quo,
    output logic [D_W-1:0] o_rem
);
    localparam int CW = $clog2(N_W + 1);

    logic           r_busy;
    logic [CW-1:0]  r_cnt;
    logic [N_W-1:0] r_quo;
    logic [D_W-1:0] r_rem;
    logic [D_W-1:0] r_den;
    logic [D_W:0]   trial;
    logic           ge;

    assign trial = {r_rem, r_quo[N_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start && !r_busy) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(N_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? D_W'(trial - {1'b0, r_den}) : D_W'(trial);
            r_quo <= {r_quo[N_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

// ===== sv/kftm_queue.sv =====
// Two-entry item queue between the front and back parts.
// Depends on kftm_pkg for the item type.
module kftm_queue import kftm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);
    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== sv/kftm_front.sv =====
// Front part: takes items, scales time to ticks, wraps by the duration.
// Depends on kftm_pkg and kftm_div.
module kftm_front import kftm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        push,
    output logic        full,
    input  logic        i_func,
    input  logic [7:0]  i_key_slot,
    input  logic [31:0] i_key_time,
    input  logic [31:0] i_time_sec,
    output logic        o_q_push,
    output t_job        o_q_data,
    input  logic        i_q_full
);
    t_fst        r_st, n_st;
    t_job        r_job;
    logic [32:0] r_tsum;
    logic [39:0] r_eff;
    logic [72:0] r_acc;
    logic [1:0]  r_k;

    logic [31:0] rate;
    logic [47:0] eff48;
    logic [15:0] chunk;
    logic [56:0] ticks57;
    logic [57:0] sub;
    logic [57:0] ticks;
    logic [31:0] dur;
    logic        accept;
    logic        div_start;
    logic        div_busy;
    logic [57:0] quo;
    logic [31:0] rem;
    logic        lim_hit;

    assign rate    = (i_cfg.rate != '0) ? i_cfg.rate : DEFAULT_RATE;
    assign dur     = (i_cfg.dur != '0) ? i_cfg.dur : 32'd1;
    assign eff48   = {8'd0, r_eff};
    assign chunk   = eff48[16*r_k +: 16];
    assign ticks57 = r_acc[72:16];
    assign sub     = {26'd0, 16'(-i_cfg.tick_off), 16'd0};
    assign lim_hit = !i_cfg.limit[16] && (i_cfg.limit[15:0] != '0)
                     && (quo >= {42'd0, i_cfg.limit[15:0]});

    // tick total with the whole-tick offset, clamped at zero
    always_comb begin
        if (!i_cfg.tick_off[15]) begin
            ticks = 58'(ticks57) + {26'd0, i_cfg.tick_off, 16'd0};
        end else begin
            ticks = (58'(ticks57) > sub) ? 58'(ticks57) - sub : '0;
        end
    end

    kftm_div #(.N_W(58), .D_W(32)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (ticks),
        .i_divisor  (dur),
        .o_busy     (div_busy),
        .o_quo      (quo),
        .o_rem      (rem)
    );

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            F_IDLE: if (push) n_st = (i_func == FUNC_WRITE) ? F_EMIT : F_MUL;
            F_MUL:  if (r_k == 2'd2) n_st = F_OFFS;
            F_OFFS: n_st = F_DIV;
            F_DIV:  if (!div_busy) n_st = F_EMIT;
            F_EMIT: if (!i_q_full) n_st = F_IDLE;
            default: n_st = F_IDLE;
        endcase
    end

    always_comb begin
        full      = r_st != F_IDLE;
        accept    = push && (r_st == F_IDLE);
        div_start = r_st == F_OFFS;
        o_q_push  = r_st == F_EMIT;
        o_q_data  = r_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= F_IDLE;
        else          r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            F_IDLE: begin
                if (accept) begin
                    r_job.func  <= i_func;
                    r_job.slot  <= i_key_slot;
                    r_job.value <= i_key_time;
                    r_tsum      <= 33'(i_time_sec) + 33'(i_cfg.toff);
                    r_eff       <= 40'((48'(rate) * 48'(i_cfg.speed)) >> 8);
                    r_acc       <= '0;
                    r_k         <= '0;
                end
            end
            F_MUL: begin
                r_acc <= r_acc + (73'(49'(r_tsum) * 49'(chunk)) << (16 * r_k));
                r_k   <= r_k + 1'b1;
            end
            F_OFFS: ;
            F_DIV: begin
                if (!div_busy) begin
                    r_job.play_count <= (quo > 58'd65535) ? 16'hFFFF : quo[15:0];
                    if (lim_hit) begin
                        r_job.value <= rem;
                        r_job.done  <= 1'b1;
                    end else if (i_cfg.mode == MODE_SINGLE) begin
                        r_job.value <= rem;
                        r_job.done  <= quo > 58'd1;
                    end else if (i_cfg.mode == MODE_PING && quo[0]) begin
                        r_job.value <= dur - rem;
                        r_job.done  <= 1'b0;
                    end else begin
                        r_job.value <= rem;
                        r_job.done  <= 1'b0;
                    end
                end
            end
            F_EMIT: ;
            default: ;
        endcase
    end
endmodule

// ===== sv/kftm_back.sv =====
// Back part: key-time table, upper-bound scan, weight and result register.
// Depends on kftm_pkg and kftm_div.
module kftm_back import kftm_pkg::*; #(
    parameter int MAX_KEYS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [8:0]  i_kcount,
    input  t_job        i_q_data,
    input  logic        i_q_empty,
    output logic        o_q_pop,
    input  logic        pop,
    output logic        empty,
    output logic [31:0] o_anim_time,
    output logic [15:0] o_play_count,
    output logic        o_done_res,
    output logic [7:0]  o_frame_index,
    output logic [15:0] o_weight,
    output logic        o_hold_last
);
    localparam int AW = $clog2(MAX_KEYS);
    localparam int NW = $clog2(MAX_KEYS + 1);

    logic [31:0] r_mem [MAX_KEYS];
    logic [31:0] r_rdata;

    t_bst        r_st, n_st;
    logic [31:0] r_t;
    logic [15:0] r_cnt;
    logic        r_done;
    logic [31:0] r_last;
    logic [31:0] r_prev;
    logic [31:0] r_kidx;
    logic [31:0] r_knext;
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_idx;
    logic        r_hnext;
    logic        r_hold;
    logic [15:0] r_w;
    logic        r_ovalid;

    logic [NW-1:0] n_keys;
    logic [AW-1:0] last_addr;
    logic [AW-1:0] rd_addr;
    logic          gt;
    logic          at_last;
    logic          hold;
    logic          use_div;
    logic          wr_en;
    logic          take;
    logic          out_free;
    logic          div_start;
    logic          div_busy;
    logic [47:0]   quo;
    logic [31:0]   rem;

    always_comb begin
        if (i_kcount == '0)                    n_keys = NW'(1);
        else if (32'(i_kcount) > MAX_KEYS)     n_keys = NW'(MAX_KEYS);
        else                                   n_keys = NW'(i_kcount);
    end

    assign last_addr = AW'(n_keys - NW'(1));
    assign gt        = r_rdata > r_t;
    assign at_last   = r_i == last_addr;
    assign hold      = r_hnext || (r_t > r_last);
    assign use_div   = !hold && (r_t >= r_kidx) && (r_knext > r_kidx);
    assign out_free  = !r_ovalid || pop;
    assign take      = (r_st == B_IDLE) && !i_q_empty;
    assign wr_en     = take && (i_q_data.func == FUNC_WRITE)
                       && (32'(i_q_data.slot) < MAX_KEYS);

    kftm_div #(.N_W(48), .D_W(32)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_t - r_kidx, 16'd0}),
        .i_divisor  (r_knext - r_kidx),
        .o_busy     (div_busy),
        .o_quo      (quo),
        .o_rem      (rem)
    );

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            B_IDLE: if (take && i_q_data.func != FUNC_WRITE) n_st = B_LAST;
            B_LAST: n_st = B_SCAN;
            B_SCAN: begin
                if (gt && r_i == '0 && n_keys != NW'(1)) n_st = B_NEXT;
                else if (gt || at_last)                 n_st = B_WGT;
            end
            B_NEXT: n_st = B_WGT;
            B_WGT:  n_st = use_div ? B_DIV : B_OUT;
            B_DIV:  if (!div_busy) n_st = B_OUT;
            B_OUT:  if (out_free) n_st = B_IDLE;
            default: n_st = B_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop   = take;
        div_start = (r_st == B_WGT) && use_div;
        empty     = !r_ovalid;
        unique case (r_st)
            B_IDLE:  rd_addr = last_addr;
            B_LAST:  rd_addr = '0;
            B_SCAN:  rd_addr = (gt && r_i == '0) ? AW'(1) : AW'(r_i + 1'b1);
            default: rd_addr = r_i;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[AW'(32'(i_q_data.slot))] <= i_q_data.value;
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == B_OUT && out_free) r_ovalid <= 1'b1;
            else if (pop)                  r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            B_IDLE: begin
                r_t    <= i_q_data.value;
                r_cnt  <= i_q_data.play_count;
                r_done <= i_q_data.done;
                r_i    <= '0;
            end
            B_LAST: r_last <= r_rdata;
            B_SCAN: begin
                r_prev <= r_rdata;
                if (gt && r_i != '0) begin
                    r_idx   <= AW'(r_i - 1'b1);
                    r_kidx  <= r_prev;
                    r_knext <= r_rdata;
                    r_hnext <= 1'b0;
                end else if (gt) begin
                    r_idx   <= '0;
                    r_kidx  <= r_rdata;
                    r_hnext <= n_keys == NW'(1);
                end else if (at_last) begin
                    r_idx   <= r_i;
                    r_hnext <= 1'b1;
                end else begin
                    r_i <= AW'(r_i + 1'b1);
                end
            end
            B_NEXT: r_knext <= r_rdata;
            B_WGT: begin
                r_hold <= hold;
                r_w    <= '0;
            end
            B_DIV: begin
                if (!div_busy) r_w <= (quo > 48'd65535) ? 16'hFFFF : quo[15:0];
            end
            B_OUT: begin
                if (out_free) begin
                    o_anim_time   <= r_t;
                    o_play_count  <= r_cnt;
                    o_done_res    <= r_done;
                    o_frame_index <= 8'(r_idx);
                    o_weight      <= r_w;
                    o_hold_last   <= r_hold;
                end
            end
            default: ;
        endcase
    end
endmodule
